[hw/rtl/energy_weighted_mean_rms_macros.svh]
// ----------------------------------------------------------------------------
// Energy-weighted mean/RMS assertion macros
// Shorthand for clocked assertions with a synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef ENERGY_WEIGHTED_MEAN_RMS_MACROS_SVH
`define ENERGY_WEIGHTED_MEAN_RMS_MACROS_SVH

// generic form: explicit clock and reset
`define EWMR_ASSERT_AT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// block clock and reset
`define EWMR_ASSERT(label, prop, msg) \
    `EWMR_ASSERT_AT(label, aclk, aresetn, prop, msg)

`endif

[hw/rtl/ewmr_pkg.sv]
// ----------------------------------------------------------------------------
// ewmr_pkg
// Shared types and constants of the energy-weighted mean/RMS block.
// ----------------------------------------------------------------------------
`default_nettype none

package ewmr_pkg;

    localparam int QB         = 33;  // quotient bits of the shared divider
    localparam int DIV_STEPS  = QB;
    localparam int SQRT_STEPS = 17;  // radicand below 2^34, two bits a step
    localparam int RAD_W      = 34;
    localparam int STEP_W     = 6;
    localparam int ETOT_W     = 26;
    localparam logic [63:0] ETOT_MAX = 64'd67108863;

    typedef enum logic [2:0] {
        S_ACCUM,
        S_DRAIN,
        S_DIVM,
        S_LDS,
        S_DIVS,
        S_LDR,
        S_SQRT,
        S_OUT
    } state_t;

    typedef struct packed {
        logic take;         // accept a beat this cycle
        logic div_ld_mean;  // snapshot sums, start mean division
        logic div_step;
        logic div_ld_sq;    // save mean, start square-sum division
        logic sqrt_ld;
        logic sqrt_step;
        logic out_ld;
    } cmd_t;

    typedef struct packed {
        logic busy;      // accumulation pipeline holds items
        logic out_free;  // output register can take a result
    } stat_t;

endpackage

`default_nettype wire

[hw/rtl/ewmr_ctrl.sv]
// ----------------------------------------------------------------------------
// ewmr_ctrl
// Sequencer: intake, pipeline drain, divisions, square root, result load.
// ----------------------------------------------------------------------------
`default_nettype none

module ewmr_ctrl
    import ewmr_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_tvalid,
    input  wire logic  s_tlast,
    output logic       s_tready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_ACCUM;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            S_ACCUM: if (s_tvalid && s_tlast) state_next = S_DRAIN;
            S_DRAIN: if (!stat.busy) begin
                state_next = S_DIVM;
                step_next  = '0;
            end
            S_DIVM: begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1)) state_next = S_LDS;
            end
            S_LDS: begin
                state_next = S_DIVS;
                step_next  = '0;
            end
            S_DIVS: begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1)) state_next = S_LDR;
            end
            S_LDR: begin
                state_next = S_SQRT;
                step_next  = '0;
            end
            S_SQRT: begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(SQRT_STEPS - 1)) state_next = S_OUT;
            end
            S_OUT: if (stat.out_free) state_next = S_ACCUM;
            default: state_next = S_ACCUM;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            S_ACCUM: begin
                s_tready = 1'b1;
                cmd.take = s_tvalid;
            end
            S_DRAIN: cmd.div_ld_mean = !stat.busy;
            S_DIVM:  cmd.div_step    = 1'b1;
            S_LDS:   cmd.div_ld_sq   = 1'b1;
            S_DIVS:  cmd.div_step    = 1'b1;
            S_LDR:   cmd.sqrt_ld     = 1'b1;
            S_SQRT:  cmd.sqrt_step   = 1'b1;
            S_OUT:   cmd.out_ld      = stat.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/ewmr_dp.sv]
// ----------------------------------------------------------------------------
// ewmr_dp
// Datapath: distance and product pipeline, set accumulators, shared
// restoring divider, bit-pair square root and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "energy_weighted_mean_rms_macros.svh"

module ewmr_dp
    import ewmr_pkg::*;
#(
    parameter int MAX_ITEMS = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire cmd_t        cmd,
    output stat_t            stat,
    input  wire logic [47:0] s_tdata,
    input  wire logic        s_tlast,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_data,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,
    output logic [1:0]       m_tuser
);

    localparam int LOG    = $clog2(MAX_ITEMS);
    localparam int CNT_W  = $clog2(MAX_ITEMS + 2);
    localparam int ESUM_W = 16 + LOG;
    localparam int WV_W   = 33 + LOG;
    localparam int SQ_W   = 48 + LOG;
    localparam int REM_W  = ESUM_W + QB;
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_ITEMS);
    localparam logic [CNT_W-1:0] CNT_OVER = CNT_W'(MAX_ITEMS + 1);

    // intake stage
    logic               angle_reg;
    logic               in_set_reg;
    logic signed [15:0] centre_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               ovf_reg;

    logic [15:0]        in_e;
    logic signed [15:0] in_v, in_c, c_use;
    logic signed [16:0] diff, diff_w;
    logic [16:0]        mag;
    logic               acc_en;

    // product pipeline
    logic               p1_reg, p2_reg, p3_reg;
    logic [15:0]        e1_reg, e2_reg;
    logic signed [15:0] v1_reg;
    logic [16:0]        mag1_reg;
    logic signed [32:0] ev2_reg;
    logic [33:0]        sq2_reg;
    logic [47:0]        prod3_reg;
    logic [49:0]        prod3_full;

    // accumulators and snapshot
    logic [ESUM_W-1:0]      esum_reg, esum_s_reg;
    logic signed [WV_W-1:0] wvs_reg;
    logic [SQ_W-1:0]        wss_reg, wss_s_reg;
    logic [WV_W-1:0]        wvs_mag;
    logic                   neg_reg;

    // divider and square root
    logic [REM_W-1:0]  rem_reg, dsh_reg;
    logic [QB-1:0]     q_reg;
    logic [15:0]       mean_reg;
    logic [RAD_W-1:0]  x_reg, res_reg, bit_reg;
    logic [RAD_W-1:0]  trial;

    // output register
    logic              out_valid_reg;
    logic [15:0]       mean_o_reg, rms_o_reg;
    logic [ETOT_W-1:0] etot_o_reg;
    logic              empty_o_reg, ovf_o_reg;
    logic              empty_s;
    logic [63:0]       esum_ext;

    assign in_e = s_tdata[15:0];
    assign in_v = $signed(s_tdata[31:16]);
    assign in_c = $signed(s_tdata[47:32]);

    // first beat of a set supplies the centre
    assign c_use  = in_set_reg ? centre_reg : in_c;
    assign diff   = {in_v[15], in_v} - {c_use[15], c_use};
    assign diff_w = angle_reg ? {diff[15], diff[15:0]} : diff;
    assign mag    = diff_w[16] ? (~diff_w + 17'd1) : diff_w;
    assign acc_en = cmd.take && (count_reg < CNT_MAX);

    always_comb begin
        count_next = count_reg;
        if (cmd.take) count_next = acc_en ? count_reg + 1'b1 : CNT_OVER;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_reg  <= 1'b0;
            in_set_reg <= 1'b0;
            centre_reg <= '0;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
        end else begin
            if (cfg_valid) angle_reg <= cfg_data;
            if (cmd.take) begin
                if (s_tlast) begin
                    in_set_reg <= 1'b0;
                    count_reg  <= '0;
                    ovf_reg    <= (count_next > CNT_MAX);
                end else begin
                    in_set_reg <= 1'b1;
                    centre_reg <= c_use;
                    count_reg  <= count_next;
                end
            end
        end
    end

    assign prod3_full = e2_reg * sq2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_reg <= 1'b0;
            p2_reg <= 1'b0;
            p3_reg <= 1'b0;
        end else begin
            p1_reg <= acc_en;
            p2_reg <= p1_reg;
            p3_reg <= p2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        e1_reg    <= in_e;
        v1_reg    <= in_v;
        mag1_reg  <= mag;
        e2_reg    <= e1_reg;
        ev2_reg   <= $signed({1'b0, e1_reg}) * v1_reg;
        sq2_reg   <= mag1_reg * mag1_reg;
        prod3_reg <= prod3_full[47:0];
    end

    assign wvs_mag = wvs_reg[WV_W-1] ? WV_W'(-wvs_reg) : WV_W'(wvs_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            esum_reg <= '0;
            wvs_reg  <= '0;
            wss_reg  <= '0;
        end else if (cmd.div_ld_mean) begin
            esum_reg <= '0;
            wvs_reg  <= '0;
            wss_reg  <= '0;
        end else begin
            if (p2_reg) begin
                esum_reg <= esum_reg + ESUM_W'(e2_reg);
                wvs_reg  <= wvs_reg + WV_W'(ev2_reg);
            end
            if (p3_reg) wss_reg <= wss_reg + SQ_W'(prod3_reg);
        end
    end

    assign trial = res_reg + bit_reg;

    always_ff @(posedge aclk) begin
        if (cmd.div_ld_mean) begin
            esum_s_reg <= esum_reg;
            wss_s_reg  <= wss_reg;
            neg_reg    <= wvs_reg[WV_W-1];
            rem_reg    <= REM_W'(wvs_mag);
            dsh_reg    <= REM_W'(esum_reg) << (QB - 1);
            q_reg      <= '0;
        end else if (cmd.div_ld_sq) begin
            mean_reg <= neg_reg ? 16'(-q_reg[15:0]) : q_reg[15:0];
            rem_reg  <= REM_W'(wss_s_reg);
            dsh_reg  <= REM_W'(esum_s_reg) << (QB - 1);
            q_reg    <= '0;
        end else if (cmd.div_step) begin
            if (rem_reg >= dsh_reg) begin
                rem_reg <= rem_reg - dsh_reg;
                q_reg   <= {q_reg[QB-2:0], 1'b1};
            end else begin
                q_reg <= {q_reg[QB-2:0], 1'b0};
            end
            dsh_reg <= dsh_reg >> 1;
        end
        if (cmd.sqrt_ld) begin
            x_reg   <= RAD_W'(q_reg);
            res_reg <= '0;
            bit_reg <= RAD_W'(1) << (RAD_W - 2);
        end else if (cmd.sqrt_step) begin
            if (x_reg >= trial) begin
                x_reg   <= x_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end else begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign empty_s  = (esum_s_reg == '0);
    assign esum_ext = 64'(esum_s_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_ld) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_ld) begin
            empty_o_reg <= empty_s;
            mean_o_reg  <= empty_s ? 16'd0 : mean_reg;
            rms_o_reg   <= empty_s ? 16'd0 : res_reg[15:0];
            etot_o_reg  <= (esum_ext > ETOT_MAX) ? ETOT_MAX[ETOT_W-1:0]
                                                 : esum_ext[ETOT_W-1:0];
            ovf_o_reg   <= ovf_reg;
        end
    end

    assign stat.busy     = p1_reg || p2_reg || p3_reg;
    assign stat.out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, etot_o_reg, rms_o_reg, mean_o_reg};
    assign m_tuser  = {ovf_o_reg, empty_o_reg};

    `EWMR_ASSERT(a_count_bound, count_reg <= CNT_OVER, "item count past capacity mark")
    `EWMR_ASSERT(a_drained_first, cmd.div_ld_mean |-> !stat.busy, "division before drain")
    `EWMR_ASSERT(a_empty_zero, (out_valid_reg && empty_o_reg) |-> (mean_o_reg == 16'd0 && rms_o_reg == 16'd0), "empty set with nonzero result")

endmodule

`default_nettype wire

[hw/rtl/energy_weighted_mean_rms.sv]
// Accumulation takes one beat per cycle through a three-stage product pipeline.
// A beat with tlast closes the set: intake stalls through the pipeline drain,
// two 33-step divisions on one shared divider, a 17-step square root and the
// loads, and while the output register still holds an unaccepted result.
// The result then sits in the output register; the next set may start at once.
// Reset (aresetn, synchronous, active low) clears the set state and angle_mode.
// ----------------------------------------------------------------------------
// energy_weighted_mean_rms
// Energy-weighted mean and RMS of a set of (energy, value) beats.
// ----------------------------------------------------------------------------
`default_nettype none

module energy_weighted_mean_rms
    import ewmr_pkg::*;
#(
    parameter int MAX_ITEMS = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // energy[15:0], value[31:16], centre[47:32]
    input  wire logic        s_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data,  // angle_mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // mean[15:0], rms[31:16], energy_total[57:32], zeros
    output logic [1:0]       m_tuser    // empty_res[0], overflow[1]
);

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    ewmr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ewmr_dp #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire
